// ===== src/deadline_sorted_timer_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// Deadline sorted timer table: assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_SORTED_TIMER_TABLE_TOP_DEFINES_SVH
`define DEADLINE_SORTED_TIMER_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSTT_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSTT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dstt_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadline sorted timer table: shared package
// Codes, item layouts and default configuration shared by all modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dstt_pkg;

    // Default table size and reset value of the minimum alarm distance
    localparam int DSTT_NUM_TIMERS = 8;
    localparam logic [15:0] MIN_TIMEOUT_RST = 16'd3;

    // Operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STOP  = 1'b1;

    // Status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_INVALID = 1'b1;

    // Alarm actions
    localparam logic [1:0] ACT_LEAVE   = 2'd0;
    localparam logic [1:0] ACT_PROG    = 2'd1;
    localparam logic [1:0] ACT_DISABLE = 2'd2;

    // Input item payload, last field in the lowest bits
    typedef struct packed {
        logic [31:0] now_ssr;
        logic [31:0] reload_ticks;
        logic [2:0]  timer_id;
    } in_item_t;

    // Result item payload, last field in the lowest bits
    typedef struct packed {
        logic        list_empty;
        logic [2:0]  head_id;
        logic [31:0] alarm_subseconds;
        logic [1:0]  alarm_action;
        logic        status;
    } res_t;

    localparam int IN_BITS     = $bits(in_item_t);
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int RES_W       = $bits(res_t);
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    // Memory port control
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== src/dstt_ram.sv =====
// ----------------------------------------------------------------------------
// Deadline sorted timer table: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dstt_ram
    import dstt_pkg::*;
#(
    parameter int DEPTH = DSTT_NUM_TIMERS,
    parameter int WIDTH = 32
)
(
    input  wire                      clk,
    input  mem_ctl_t                 ctl,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on request, hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/dstt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deadline sorted timer table: sequencer
// Decodes an item, walks the linked deadline list in the RAMs, relinks
// entries, re-arms the head and loads the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dstt_ctrl
    import dstt_pkg::*;
#(
    parameter int NUM_TIMERS = DSTT_NUM_TIMERS
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    // input item
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire                           in_op,
    input  in_item_t                      in_item,
    // result item
    output logic                          out_valid,
    input  wire                           out_ready,
    output res_t                          out_res,
    // configuration
    input  wire                           cfg_we,
    input  wire [15:0]                    cfg_wdata,
    // deadline RAM
    output mem_ctl_t                      dl_ctl,
    output logic [$clog2(NUM_TIMERS)-1:0] dl_waddr,
    output logic [31:0]                   dl_wdata,
    output logic [$clog2(NUM_TIMERS)-1:0] dl_raddr,
    input  wire [31:0]                    dl_rd,
    // link RAM: {end mark, successor}
    output mem_ctl_t                      lk_ctl,
    output logic [$clog2(NUM_TIMERS)-1:0] lk_waddr,
    output logic [$clog2(NUM_TIMERS):0]   lk_wdata,
    output logic [$clog2(NUM_TIMERS)-1:0] lk_raddr,
    input  wire [$clog2(NUM_TIMERS):0]    lk_rd
);

    localparam int IDX_W = $clog2(NUM_TIMERS);
    localparam int IDW_W = IDX_W + 3;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_HEAD   = 4'd2;
    localparam logic [3:0] S_STEP   = 4'd3;
    localparam logic [3:0] S_CMP    = 4'd4;
    localparam logic [3:0] S_TAIL   = 4'd5;
    localparam logic [3:0] S_LINK   = 4'd6;
    localparam logic [3:0] S_SHEAD  = 4'd7;
    localparam logic [3:0] S_ARM    = 4'd8;
    localparam logic [3:0] S_RSTEP  = 4'd9;
    localparam logic [3:0] S_UNLINK = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    // control state
    logic [3:0]            state_reg, state_next;
    logic [NUM_TIMERS-1:0] queued_reg, queued_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic                  list_valid_reg, list_valid_next;
    logic [31:0]           time_base_reg, time_base_next;
    logic [15:0]           min_timeout_reg, min_timeout_next;
    logic                  out_valid_reg, out_valid_next;

    // item working registers
    logic                  op_reg, op_next;
    logic [IDX_W-1:0]      id_reg, id_next;
    logic                  id_bad_reg, id_bad_next;
    logic [31:0]           now_reg, now_next;
    logic [31:0]           ticks_reg, ticks_next;
    logic [31:0]           elapsed_reg, elapsed_next;
    logic [31:0]           dnew_reg, dnew_next;
    logic [31:0]           floor_reg, floor_next;
    logic [31:0]           dn_reg, dn_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      nxt_reg, nxt_next;
    logic                  status_reg, status_next;
    logic [1:0]            act_reg, act_next;
    res_t                  out_res_reg, out_res_next;

    logic                  lk_end;
    logic [IDX_W-1:0]      lk_ptr;
    logic [IDW_W-1:0]      id_wide;
    logic [IDW_W-1:0]      head_wide;
    logic [31:0]           min_ext;
    logic [31:0]           arm_d;
    logic [31:0]           arm_dn;

    assign lk_end    = lk_rd[IDX_W];
    assign lk_ptr    = lk_rd[IDX_W-1:0];
    assign id_wide   = {{IDX_W{1'b0}}, in_item.timer_id};
    assign head_wide = {3'b000, head_reg};
    assign min_ext   = {16'h0000, min_timeout_reg};

    // Clamp the new head deadline to elapsed plus minimum
    assign arm_d  = (op_reg == OP_STOP) ? dl_rd : dnew_reg;
    assign arm_dn = (arm_d < floor_reg) ? floor_reg : arm_d;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        state_next       = state_reg;
        queued_next      = queued_reg;
        running_next     = running_reg;
        head_next        = head_reg;
        list_valid_next  = list_valid_reg;
        time_base_next   = time_base_reg;
        min_timeout_next = min_timeout_reg;
        out_valid_next   = out_valid_reg;
        op_next          = op_reg;
        id_next          = id_reg;
        id_bad_next      = id_bad_reg;
        now_next         = now_reg;
        ticks_next       = ticks_reg;
        elapsed_next     = elapsed_reg;
        dnew_next        = dnew_reg;
        floor_next       = floor_reg;
        dn_next          = dn_reg;
        cur_next         = cur_reg;
        nxt_next         = nxt_reg;
        status_next      = status_reg;
        act_next         = act_reg;
        out_res_next     = out_res_reg;

        dl_ctl   = '0;
        dl_waddr = '0;
        dl_wdata = '0;
        dl_raddr = '0;
        lk_ctl   = '0;
        lk_waddr = '0;
        lk_wdata = '0;
        lk_raddr = '0;

        // take configuration writes
        if (cfg_we)
        begin
            min_timeout_next = cfg_wdata;
        end

        // drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // latch the item, convert the subsecond value to ticks
                if (in_valid)
                begin
                    op_next      = in_op;
                    id_next      = id_wide[IDX_W-1:0];
                    id_bad_next  = (id_wide >= IDW_W'(NUM_TIMERS));
                    now_next     = ~in_item.now_ssr;
                    ticks_next   = (in_item.reload_ticks < min_ext) ? min_ext
                                                                    : in_item.reload_ticks;
                    elapsed_next = ~in_item.now_ssr - time_base_reg;
                    state_next   = S_PREP;
                end
            end

            S_PREP:
            begin
                status_next = ST_OK;
                act_next    = ACT_LEAVE;
                if (id_bad_reg ||
                    ((op_reg == OP_START) && (queued_reg[id_reg] || running_reg[id_reg])))
                begin
                    status_next = ST_INVALID;
                    state_next  = S_FIN;
                end
                else if (op_reg == OP_START)
                begin
                    queued_next[id_reg]  = 1'b1;
                    running_next[id_reg] = 1'b1;
                    if (!list_valid_reg)
                    begin
                        // empty list: latch the time base and take the head
                        time_base_next  = now_reg;
                        head_next       = id_reg;
                        list_valid_next = 1'b1;
                        dl_ctl.we       = 1'b1;
                        dl_waddr        = id_reg;
                        dl_wdata        = ticks_reg;
                        lk_ctl.we       = 1'b1;
                        lk_waddr        = id_reg;
                        lk_wdata        = {1'b1, {IDX_W{1'b0}}};
                        dn_next         = ticks_reg;
                        act_next        = ACT_PROG;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        // fetch the head entry
                        dnew_next  = ticks_reg + elapsed_reg;
                        floor_next = elapsed_reg + min_ext;
                        dl_ctl.re  = 1'b1;
                        dl_raddr   = head_reg;
                        lk_ctl.re  = 1'b1;
                        lk_raddr   = head_reg;
                        state_next = S_HEAD;
                    end
                end
                else if (!list_valid_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    running_next[id_reg] = 1'b0;
                    floor_next           = elapsed_reg + min_ext;
                    lk_ctl.re            = 1'b1;
                    lk_raddr             = head_reg;
                    if (head_reg == id_reg)
                    begin
                        queued_next[id_reg] = 1'b0;
                        state_next          = S_SHEAD;
                    end
                    else if (queued_reg[id_reg])
                    begin
                        queued_next[id_reg] = 1'b0;
                        cur_next            = head_reg;
                        state_next          = S_RSTEP;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_HEAD:
            begin
                if (dnew_reg < dl_rd)
                begin
                    // new head in front of the old one
                    lk_ctl.we  = 1'b1;
                    lk_waddr   = id_reg;
                    lk_wdata   = {1'b0, head_reg};
                    head_next  = id_reg;
                    state_next = S_ARM;
                end
                else
                begin
                    // store the deadline, walk from the head
                    dl_ctl.we  = 1'b1;
                    dl_waddr   = id_reg;
                    dl_wdata   = dnew_reg;
                    cur_next   = head_reg;
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                if (lk_end)
                begin
                    lk_ctl.we  = 1'b1;
                    lk_waddr   = cur_reg;
                    lk_wdata   = {1'b0, id_reg};
                    state_next = S_TAIL;
                end
                else
                begin
                    // fetch the successor
                    nxt_next   = lk_ptr;
                    dl_ctl.re  = 1'b1;
                    dl_raddr   = lk_ptr;
                    lk_ctl.re  = 1'b1;
                    lk_raddr   = lk_ptr;
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (dnew_reg > dl_rd)
                begin
                    cur_next   = nxt_reg;
                    state_next = S_STEP;
                end
                else
                begin
                    lk_ctl.we  = 1'b1;
                    lk_waddr   = id_reg;
                    lk_wdata   = {1'b0, nxt_reg};
                    state_next = S_LINK;
                end
            end

            S_TAIL:
            begin
                // mark the new entry as the last one
                lk_ctl.we  = 1'b1;
                lk_waddr   = id_reg;
                lk_wdata   = {1'b1, {IDX_W{1'b0}}};
                state_next = S_FIN;
            end

            S_LINK:
            begin
                lk_ctl.we  = 1'b1;
                lk_waddr   = cur_reg;
                lk_wdata   = {1'b0, id_reg};
                state_next = S_FIN;
            end

            S_SHEAD:
            begin
                if (!lk_end)
                begin
                    // advance the head, fetch its deadline
                    head_next  = lk_ptr;
                    dl_ctl.re  = 1'b1;
                    dl_raddr   = lk_ptr;
                    state_next = S_ARM;
                end
                else
                begin
                    list_valid_next = 1'b0;
                    act_next        = ACT_DISABLE;
                    state_next      = S_FIN;
                end
            end

            S_ARM:
            begin
                dl_ctl.we  = 1'b1;
                dl_waddr   = head_reg;
                dl_wdata   = arm_dn;
                dn_next    = arm_dn;
                act_next   = ACT_PROG;
                state_next = S_FIN;
            end

            S_RSTEP:
            begin
                if (lk_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    lk_ctl.re = 1'b1;
                    lk_raddr  = lk_ptr;
                    if (lk_ptr == id_reg)
                    begin
                        state_next = S_UNLINK;
                    end
                    else
                    begin
                        cur_next = lk_ptr;
                    end
                end
            end

            S_UNLINK:
            begin
                // predecessor takes over the removed entry's link
                lk_ctl.we  = 1'b1;
                lk_waddr   = cur_reg;
                lk_wdata   = lk_rd;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                // load the result register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                = 1'b1;
                    out_res_next.status           = status_reg;
                    out_res_next.alarm_action     = act_reg;
                    out_res_next.alarm_subseconds = (act_reg == ACT_PROG)
                                                    ? ~(time_base_reg + dn_reg) : 32'd0;
                    out_res_next.head_id          = list_valid_reg ? head_wide[2:0] : 3'd0;
                    out_res_next.list_empty       = !list_valid_reg;
                    state_next                    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            queued_reg      <= '0;
            running_reg     <= '0;
            head_reg        <= '0;
            list_valid_reg  <= 1'b0;
            time_base_reg   <= '0;
            min_timeout_reg <= MIN_TIMEOUT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            queued_reg      <= queued_next;
            running_reg     <= running_next;
            head_reg        <= head_next;
            list_valid_reg  <= list_valid_next;
            time_base_reg   <= time_base_next;
            min_timeout_reg <= min_timeout_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        id_bad_reg  <= id_bad_next;
        now_reg     <= now_next;
        ticks_reg   <= ticks_next;
        elapsed_reg <= elapsed_next;
        dnew_reg    <= dnew_next;
        floor_reg   <= floor_next;
        dn_reg      <= dn_next;
        cur_reg     <= cur_next;
        nxt_reg     <= nxt_next;
        status_reg  <= status_next;
        act_reg     <= act_next;
        out_res_reg <= out_res_next;
    end

endmodule

`default_nettype wire

// ===== src/deadline_sorted_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// Deadline sorted timer table: top level
// Deadline sorted list of one-shot timers with alarm reprogramming results.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser holds
//   the operation (start or stop). Each item yields exactly one result item
//   on m_tvalid/m_tready/m_tdata. min_timeout is written through cfg_we and
//   cfg_wdata; the user must write it only while the block is idle, which
//   the block itself does not enforce. When no entry is read, an item goes
//   from decode to the result register; a new head or a stop of the head
//   reads the head entry, then re-arms or disables the alarm. A sorted
//   insert reads and compares each entry passed, a non-head stop its link;
//   the next item is taken the cycle after the result loads.
//   Reset empties the list, clears all queued and running marks, zeroes the
//   time base and sets min_timeout to 3; the RAMs need no clearing.
//   When the receiver stalls, the result register holds its item; the next
//   item is still accepted and processed, and waits for the register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deadline_sorted_timer_table_top
    import dstt_pkg::*;
#(
    parameter int NUM_TIMERS = DSTT_NUM_TIMERS
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    // timer_id [2:0], reload_ticks [34:3], now_ssr [66:35], zero fill
    input  wire [IN_TDATA_W-1:0]   s_tdata,
    // operation [0]
    input  wire                    s_tuser,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // status [0], alarm_action [2:1], alarm_subseconds [34:3],
    // head_id [37:35], list_empty [38], zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    input  wire                    cfg_we,
    input  wire [15:0]             cfg_wdata
);

    localparam int IDX_W = $clog2(NUM_TIMERS);

    in_item_t         in_item;
    res_t             out_res;
    mem_ctl_t         dl_ctl;
    logic [IDX_W-1:0] dl_waddr;
    logic [31:0]      dl_wdata;
    logic [IDX_W-1:0] dl_raddr;
    logic [31:0]      dl_rd;
    mem_ctl_t         lk_ctl;
    logic [IDX_W-1:0] lk_waddr;
    logic [IDX_W:0]   lk_wdata;
    logic [IDX_W-1:0] lk_raddr;
    logic [IDX_W:0]   lk_rd;

    // unpack the input item, pack the result item
    assign in_item = in_item_t'(s_tdata[IN_BITS-1:0]);
    assign m_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res};

    dstt_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_item   (in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .dl_ctl    (dl_ctl),
        .dl_waddr  (dl_waddr),
        .dl_wdata  (dl_wdata),
        .dl_raddr  (dl_raddr),
        .dl_rd     (dl_rd),
        .lk_ctl    (lk_ctl),
        .lk_waddr  (lk_waddr),
        .lk_wdata  (lk_wdata),
        .lk_raddr  (lk_raddr),
        .lk_rd     (lk_rd)
    );

    // deadline per timer
    dstt_ram #(
        .DEPTH (NUM_TIMERS),
        .WIDTH (32)
    ) u_deadline_ram (
        .clk   (clk),
        .ctl   (dl_ctl),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (dl_raddr),
        .rdata (dl_rd)
    );

    // successor and end mark per timer
    dstt_ram #(
        .DEPTH (NUM_TIMERS),
        .WIDTH (IDX_W + 1)
    ) u_link_ram (
        .clk   (clk),
        .ctl   (lk_ctl),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rd)
    );

endmodule

`default_nettype wire

// ===== src/dstt_chk.sv =====
// ----------------------------------------------------------------------------
// Deadline sorted timer table: port checker
// Watches the top level's channels and checks result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "deadline_sorted_timer_table_top_defines.svh"

module dstt_chk
    import dstt_pkg::*;
(
    input wire                   clk,
    input wire                   rst_n,
    input wire                   s_tvalid,
    input wire                   s_tready,
    input wire [OUT_TDATA_W-1:0] m_tdata,
    input wire                   m_tvalid,
    input wire                   m_tready
);

    res_t res;

    assign res = res_t'(m_tdata[RES_W-1:0]);

    // hold a stalled result
    `DSTT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `DSTT_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")

    // one item at a time: ready drops after an accept
    `DSTT_ASSERT_NEXT(a_in_busy, clk, rst_n, s_tvalid && s_tready, !s_tready, "item accepted while busy")

    // a rejected item leaves the alarm alone
    `DSTT_ASSERT_SAME(a_invalid_leave, clk, rst_n, m_tvalid && (res.status == ST_INVALID), (res.alarm_action == ACT_LEAVE) && (res.alarm_subseconds == 32'd0), "rejected item touched the alarm")

    // an empty list reports head zero and never programs the alarm
    `DSTT_ASSERT_SAME(a_empty_head, clk, rst_n, m_tvalid && res.list_empty, (res.head_id == 3'd0) && (res.alarm_action != ACT_PROG), "empty list with head or alarm")

endmodule

bind deadline_sorted_timer_table_top dstt_chk u_dstt_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
